// ===== hdl/dwcf_pkg.sv =====
// shared types, constants and frame helpers for the wheel command framer
package dwcf_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] CFG_WHEELBASE       = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_GAIN      = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_WHEEL_SPEED = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_RPM         = 8'd3;

  localparam logic [15:0] WHEELBASE_RESET       = 16'd2048;
  localparam logic [23:0] SPEED_GAIN_RESET      = 24'd65536;
  localparam logic [14:0] MAX_WHEEL_SPEED_RESET = 15'd8192;
  localparam logic [14:0] MAX_RPM_RESET         = 15'd3000;

  // depth of the queue between kinematics and framer
  localparam int QUEUE_DEPTH = 4;

  // frame layout
  localparam logic [3:0] LAST_INDEX  = 4'd9;
  localparam logic [7:0] FRAME_ADDR  = 8'h01;
  localparam logic [7:0] FRAME_CMD   = 8'h64;
  localparam logic [7:0] FRAME_MODE  = 8'h05;
  localparam logic [7:0] FRAME_PAD   = 8'h00;
  localparam logic [7:0] CRC_POLY    = 8'h8C;

  localparam logic [3:0] IDX_ADDR   = 4'd0;
  localparam logic [3:0] IDX_CMD    = 4'd1;
  localparam logic [3:0] IDX_RPM_HI = 4'd2;
  localparam logic [3:0] IDX_RPM_LO = 4'd3;
  localparam logic [3:0] IDX_MODE   = 4'd6;

  typedef struct packed {
    logic [15:0] wheelbase;
    logic [23:0] speed_gain;
    logic [14:0] max_wheel_speed;
    logic [14:0] max_rpm;
  } cfg_t;

  // one queued frame: side and signed motor speed
  typedef struct packed {
    logic        side;
    logic [15:0] rpm;
  } entry_t;

  // reflected crc-8 over one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] d);
    logic [7:0] c;
    c = crc ^ d;
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // frame bytes by index, crc byte excluded
  function automatic logic [7:0] frame_byte_at(input logic [3:0] idx, input logic [15:0] rpm);
    logic [7:0] b;
    case (idx)
      IDX_ADDR:   b = FRAME_ADDR;
      IDX_CMD:    b = FRAME_CMD;
      IDX_RPM_HI: b = rpm[15:8];
      IDX_RPM_LO: b = rpm[7:0];
      IDX_MODE:   b = FRAME_MODE;
      default:    b = FRAME_PAD;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/dwcf_front.sv =====
// command intake, inverse kinematics, limiting and speed scaling
module dwcf_front #(
  parameter int DEPTH = dwcf_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          fwd_speed,
  input  logic [15:0]          yaw_rate,
  input  dwcf_pkg::cfg_t       cfg,
  input  logic                 pop,
  output logic                 push,
  output dwcf_pkg::entry_t     push_entry
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int SW    = 35;
  localparam logic [52:0] ROUND_HALF = 53'(1) << 40;

  // command register
  logic               s0_valid;
  logic               s0_side;
  logic signed [28:0] lin_sh;
  logic signed [32:0] turn;

  // credit count: queue entries plus wheels in flight
  logic [OCC_W-1:0] occ;

  logic issue;
  logic accept;

  // limit stage
  logic        s1_valid;
  logic        s1_side;
  logic        s1_neg;
  logic        s1_satn;
  logic        s1_satp;
  logic [27:0] s1_mag;

  // gain stage
  logic        s2_valid;
  logic        s2_side;
  logic        s2_neg;
  logic        s2_satn;
  logic        s2_satp;
  logic [51:0] s2_prod;

  logic signed [SW-1:0] s_sum;
  logic signed [SW-1:0] s_wheel;
  logic signed [SW-1:0] lim;
  logic [SW-1:0]        s_abs;
  logic [52:0]          rnd;
  logic [15:0]          r16;
  logic [15:0]          rpm_max;

  assign issue    = s0_valid && (occ < OCC_W'(DEPTH));
  assign in_stall = s0_valid && !(issue && s0_side);
  assign accept   = in_valid && !in_stall;

  // command register and side sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s0_side  <= 1'b0;
    end else if (accept) begin
      s0_valid <= 1'b1;
      s0_side  <= 1'b0;
    end else if (issue) begin
      if (s0_side) begin
        s0_valid <= 1'b0;
      end else begin
        s0_side <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lin_sh <= $signed({fwd_speed, 13'b0});
      turn   <= $signed(yaw_rate) * $signed({1'b0, cfg.wheelbase});
    end
  end

  // wheel speed for the side being issued, compared against the limit
  always_comb begin
    s_sum   = 35'(lin_sh) + 35'(turn);
    s_wheel = s0_side ? -s_sum : (35'(lin_sh) - 35'(turn));
    lim     = $signed({7'b0, cfg.max_wheel_speed, 13'b0});
    s_abs   = s_wheel[SW-1] ? 35'(-s_wheel) : 35'(s_wheel);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_side <= s0_side;
    s1_neg  <= s_wheel[SW-1];
    s1_satn <= (s_wheel <= -lim);
    s1_satp <= (s_wheel >= lim);
    s1_mag  <= s_abs[27:0];
  end

  // gain multiply
  always_ff @(posedge clk) begin
    s2_side <= s1_side;
    s2_neg  <= s1_neg;
    s2_satn <= s1_satn;
    s2_satp <= s1_satp;
    s2_prod <= 52'(s1_mag) * 52'(cfg.speed_gain);
  end

  // round half away from zero, apply sign or saturation
  always_comb begin
    rnd     = 53'(s2_prod) + ROUND_HALF;
    r16     = 16'(rnd[52:41]);
    rpm_max = {1'b0, cfg.max_rpm};
    push_entry.side = s2_side;
    if (s2_satn) begin
      push_entry.rpm = -rpm_max;
    end else if (s2_satp) begin
      push_entry.rpm = rpm_max;
    end else if (s2_neg) begin
      push_entry.rpm = -r16;
    end else begin
      push_entry.rpm = r16;
    end
  end

  assign push = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ + OCC_W'(issue) - OCC_W'(pop);
    end
  end

endmodule

// ===== hdl/dwcf_queue.sv =====
// short queue of wheel speeds between kinematics and framer
module dwcf_queue #(
  parameter int DEPTH = dwcf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dwcf_pkg::entry_t push_entry,
  input  logic             pop,
  output dwcf_pkg::entry_t head,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  dwcf_pkg::entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);

endmodule

// ===== hdl/dwcf_back.sv =====
// frame serialiser with running crc and output register
module dwcf_back (
  input  logic             clk,
  input  logic             rst,
  input  dwcf_pkg::entry_t head,
  input  logic             empty,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             wheel_side,
  output logic [3:0]       byte_index,
  output logic [7:0]       frame_byte,
  output logic             last
);

  logic [3:0] idx;
  logic [7:0] crc;
  logic       emit;
  logic       at_end;
  logic [7:0] byte_now;

  assign emit     = !empty && (!out_valid || !out_stall);
  assign at_end   = (idx == dwcf_pkg::LAST_INDEX);
  assign byte_now = at_end ? crc : dwcf_pkg::frame_byte_at(idx, head.rpm);
  assign pop      = emit && at_end;

  // byte position and crc across the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      crc <= '0;
    end else if (emit) begin
      idx <= at_end ? '0 : idx + 1'b1;
      crc <= at_end ? '0 : dwcf_pkg::crc8_byte(crc, byte_now);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      wheel_side <= head.side;
      byte_index <= idx;
      frame_byte <= byte_now;
      last       <= head.side && at_end;
    end
  end

endmodule

// ===== hdl/diff_drive_wheel_command_framer.sv =====
// top level: configuration registers and the front, queue and framer
//
// Input channel (in_valid / in_stall) takes one motion command per beat while in_stall is low:
// fwd_speed and yaw_rate, signed Q4.12. Each command yields two
// ten-byte motor frames, left then right, on the output channel
// (out_valid / out_stall), one byte per beat with wheel_side, byte_index
// and last (set on the final byte of the right frame).
// The first byte of a command passes the command register, the limit and
// gain stages, the queue and the output register. Sustained throughput is
// set by the output port carrying one byte a beat, twenty bytes per command.
// The front takes a new command as soon as the previous one has issued
// both wheels, so commands queue up ahead of the framer; when the receiver
// stalls, the output byte holds, the queue fills and in_stall rises.
// Configuration writes (cfg_valid / cfg_ready, always ready) go through
// cfg_index and cfg_data; unknown indices are ignored. Write only while idle.
// Reset clears the valid flags, credit and fill counts, queue pointers, frame
// position and crc, and loads the default wheelbase, gain, speed limit and saturated motor speed.
module diff_drive_wheel_command_framer #(
  parameter int QUEUE_DEPTH = dwcf_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [15:0]                      fwd_speed,
  input  logic [15:0]                      yaw_rate,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             wheel_side,
  output logic [3:0]                       byte_index,
  output logic [7:0]                       frame_byte,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dwcf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dwcf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dwcf_pkg::cfg_t   cfg;
  dwcf_pkg::entry_t push_entry;
  dwcf_pkg::entry_t head;
  logic             push;
  logic             pop;
  logic             empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheelbase       <= dwcf_pkg::WHEELBASE_RESET;
      cfg.speed_gain      <= dwcf_pkg::SPEED_GAIN_RESET;
      cfg.max_wheel_speed <= dwcf_pkg::MAX_WHEEL_SPEED_RESET;
      cfg.max_rpm         <= dwcf_pkg::MAX_RPM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dwcf_pkg::CFG_WHEELBASE:       cfg.wheelbase       <= cfg_data[15:0];
        dwcf_pkg::CFG_SPEED_GAIN:      cfg.speed_gain      <= cfg_data[23:0];
        dwcf_pkg::CFG_MAX_WHEEL_SPEED: cfg.max_wheel_speed <= cfg_data[14:0];
        dwcf_pkg::CFG_MAX_RPM:         cfg.max_rpm         <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  dwcf_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .fwd_speed    (fwd_speed),
    .yaw_rate     (yaw_rate),
    .cfg          (cfg),
    .pop          (pop),
    .push         (push),
    .push_entry   (push_entry)
  );

  dwcf_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  dwcf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .wheel_side(wheel_side),
    .byte_index(byte_index),
    .frame_byte(frame_byte),
    .last      (last)
  );

endmodule
